[rtl/core/vtlru_pkg.sv]
// Shared constants and controller/datapath interface types for the page cache.
package vtlru_pkg;

    localparam int MAX_SLOTS_DEF  = 64;
    localparam int COORD_BITS_DEF = 8;

    localparam int MIP_W  = 4;
    localparam int SIDE_W = 4;
    localparam int SLOT_W = 3;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd8;
    localparam logic [SIDE_W-1:0] SIDE_MAX   = 4'd8;

    localparam logic OP_TOUCH   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef struct packed {
        logic load;         // capture a new request and restart the scan
        logic scan_step;    // walk the entries looking for hit and oldest
        logic decide;       // commit the result and the tag write
        logic update_step;  // walk the entries rewriting recency ranks
    } cmd_t;

    typedef struct packed {
        logic sweep_done;   // index reached the count and the read pipe is empty
        logic need_update;  // the request changes recency ranks
    } status_t;

endpackage

[rtl/core/vtlru_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vtlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/vtlru_ctrl.sv]
// Sequencer for the page cache: accept, scan, decide, recency update.
module vtlru_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output vtlru_pkg::cmd_t   cmd,
    input  vtlru_pkg::status_t status
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.sweep_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.decide = 1'b1;
                    state_next = status.need_update ? ST_UPDATE : ST_IDLE;
                end
            end
            ST_UPDATE: begin
                cmd.update_step = 1'b1;
                if (status.sweep_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.decide) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[rtl/core/vtlru_dp.sv]
// Datapath: tag and recency memories, scan pipeline, slot counters, result registers.
module vtlru_dp #(
    parameter int MAX_SLOTS  = vtlru_pkg::MAX_SLOTS_DEF,
    parameter int COORD_BITS = vtlru_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [vtlru_pkg::SIDE_W-1:0]  cfg_wr_data,
    input  logic                          s_operation,
    input  logic [COORD_BITS-1:0]         s_page_x,
    input  logic [COORD_BITS-1:0]         s_page_y,
    input  logic [vtlru_pkg::MIP_W-1:0]   s_page_mip,
    input  vtlru_pkg::cmd_t               cmd,
    output vtlru_pkg::status_t            status,
    output logic                          m_was_resident,
    output logic                          m_loaded,
    output logic [vtlru_pkg::SLOT_W-1:0]  m_slot_col,
    output logic [vtlru_pkg::SLOT_W-1:0]  m_slot_row,
    output logic                          m_evicted,
    output logic [COORD_BITS-1:0]         m_victim_x,
    output logic [COORD_BITS-1:0]         m_victim_y,
    output logic [vtlru_pkg::MIP_W-1:0]   m_victim_mip
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int TAG_W = 2 * COORD_BITS + vtlru_pkg::MIP_W;
    localparam int SQ_W  = 2 * vtlru_pkg::SIDE_W;
    localparam int CMP_W = (CNT_W > SQ_W) ? CNT_W : SQ_W;
    localparam int SW    = vtlru_pkg::SLOT_W;

    // configuration
    logic [vtlru_pkg::SIDE_W-1:0] side_reg;
    logic [vtlru_pkg::SIDE_W-1:0] eff_side;
    logic [SW-1:0]                side_last;
    logic [SQ_W-1:0]              cap_sq;
    logic                         full;

    // request and sweep state
    logic             op_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [SW-1:0]    col_reg;
    logic [SW-1:0]    row_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [SW-1:0]    rd_col_reg;
    logic [SW-1:0]    rd_row_reg;
    logic             issue;

    // scan results
    logic             found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] hit_rec_reg;
    logic [IDX_W-1:0] old_rec_reg;
    logic [IDX_W-1:0] old_idx_reg;
    logic [TAG_W-1:0] old_tag_reg;
    logic [SW-1:0]    old_col_reg;
    logic [SW-1:0]    old_row_reg;

    // update sweep parameters
    logic [IDX_W-1:0] who_reg;
    logic [IDX_W-1:0] limit_reg;
    logic             age_all_reg;

    // memory ports
    logic [TAG_W-1:0] tag_rdata;
    logic [IDX_W-1:0] rec_rdata;
    logic             tag_we;
    logic [IDX_W-1:0] tag_waddr;
    logic             rec_we;
    logic [IDX_W-1:0] rec_wdata;

    // decide terms
    logic miss_load;
    logic evict;
    logic fill;

    // result registers
    logic                        was_resident_reg;
    logic                        loaded_reg;
    logic [SW-1:0]               slot_col_reg;
    logic [SW-1:0]               slot_row_reg;
    logic                        evicted_reg;
    logic [COORD_BITS-1:0]       victim_x_reg;
    logic [COORD_BITS-1:0]       victim_y_reg;
    logic [vtlru_pkg::MIP_W-1:0] victim_mip_reg;

    always_comb begin
        if (side_reg == '0) begin
            eff_side = vtlru_pkg::SIDE_W'(1);
        end else if (side_reg > vtlru_pkg::SIDE_MAX) begin
            eff_side = vtlru_pkg::SIDE_MAX;
        end else begin
            eff_side = side_reg;
        end
    end

    assign side_last = SW'(eff_side - vtlru_pkg::SIDE_W'(1));
    assign cap_sq    = SQ_W'(eff_side) * SQ_W'(eff_side);
    assign full      = (CMP_W'(count_reg) >= CMP_W'(cap_sq)) ||
                       (count_reg == CNT_W'(MAX_SLOTS));

    assign issue     = (cmd.scan_step || cmd.update_step) && (idx_reg != count_reg);
    assign miss_load = !found_reg && (op_reg == vtlru_pkg::OP_REQUEST);
    assign evict     = miss_load && full;
    assign fill      = miss_load && !full;

    assign status.sweep_done  = (idx_reg == count_reg) && !rd_vld_reg;
    assign status.need_update = (found_reg && (op_reg == vtlru_pkg::OP_TOUCH)) || miss_load;

    // tag store: written once per load, at the decide step
    assign tag_we    = cmd.decide && miss_load;
    assign tag_waddr = evict ? old_idx_reg : count_reg[IDX_W-1:0];

    // recency rewrite: selected entry to zero, more recent ones age by one (all others after a fill)
    always_comb begin
        rec_we    = 1'b0;
        rec_wdata = rec_rdata + IDX_W'(1);
        if (cmd.update_step && rd_vld_reg) begin
            if (rd_idx_reg == who_reg) begin
                rec_we    = 1'b1;
                rec_wdata = '0;
            end else if (age_all_reg || (rec_rdata < limit_reg)) begin
                rec_we = 1'b1;
            end
        end
    end

    vtlru_ram #(
        .WIDTH (TAG_W),
        .DEPTH (MAX_SLOTS)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (tag_we),
        .wr_addr (tag_waddr),
        .wr_data (tag_reg),
        .rd_en   (issue),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (tag_rdata)
    );

    vtlru_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_SLOTS)
    ) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (rec_we),
        .wr_addr (rd_idx_reg),
        .wr_data (rec_wdata),
        .rd_en   (issue),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rec_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg   <= vtlru_pkg::SIDE_RESET;
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                side_reg <= cfg_wr_data;
            end
            if (cmd.decide && fill) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            rd_vld_reg <= issue;
        end
    end

    // sweep index and slot position of the entry being read
    always_ff @(posedge aclk) begin
        if (cmd.load || cmd.decide) begin
            idx_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end else if (issue) begin
            idx_reg <= idx_reg + CNT_W'(1);
            if (col_reg == side_last) begin
                col_reg <= '0;
                row_reg <= row_reg + SW'(1);
            end else begin
                col_reg <= col_reg + SW'(1);
            end
        end
        rd_idx_reg <= idx_reg[IDX_W-1:0];
        rd_col_reg <= col_reg;
        rd_row_reg <= row_reg;
    end

    // scan: first tag match, and the last entry holding the largest rank
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_operation;
            tag_reg     <= {s_page_mip, s_page_y, s_page_x};
            found_reg   <= 1'b0;
            old_rec_reg <= '0;
            old_idx_reg <= '0;
            old_tag_reg <= '0;
            old_col_reg <= '0;
            old_row_reg <= '0;
        end else if (cmd.scan_step && rd_vld_reg) begin
            if (!found_reg && (tag_rdata == tag_reg)) begin
                found_reg   <= 1'b1;
                hit_idx_reg <= rd_idx_reg;
                hit_rec_reg <= rec_rdata;
            end
            if (rec_rdata >= old_rec_reg) begin
                old_rec_reg <= rec_rdata;
                old_idx_reg <= rd_idx_reg;
                old_tag_reg <= tag_rdata;
                old_col_reg <= rd_col_reg;
                old_row_reg <= rd_row_reg;
            end
        end
    end

    // decide: latch update parameters and the result
    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            if (evict) begin
                who_reg   <= old_idx_reg;
                limit_reg <= old_rec_reg;
            end else if (found_reg) begin
                who_reg   <= hit_idx_reg;
                limit_reg <= hit_rec_reg;
            end else begin
                who_reg   <= count_reg[IDX_W-1:0];
                limit_reg <= '0;
            end
            age_all_reg <= fill;

            was_resident_reg <= found_reg;
            loaded_reg       <= miss_load;
            evicted_reg      <= evict;
            if (evict) begin
                slot_col_reg <= old_col_reg;
                slot_row_reg <= old_row_reg;
            end else if (fill) begin
                slot_col_reg <= col_reg;
                slot_row_reg <= row_reg;
            end else begin
                slot_col_reg <= '0;
                slot_row_reg <= '0;
            end
            if (evict) begin
                victim_x_reg   <= old_tag_reg[COORD_BITS-1:0];
                victim_y_reg   <= old_tag_reg[2*COORD_BITS-1:COORD_BITS];
                victim_mip_reg <= old_tag_reg[TAG_W-1:2*COORD_BITS];
            end else begin
                victim_x_reg   <= '0;
                victim_y_reg   <= '0;
                victim_mip_reg <= '0;
            end
        end
    end

    assign m_was_resident = was_resident_reg;
    assign m_loaded       = loaded_reg;
    assign m_slot_col     = slot_col_reg;
    assign m_slot_row     = slot_row_reg;
    assign m_evicted      = evicted_reg;
    assign m_victim_x     = victim_x_reg;
    assign m_victim_y     = victim_y_reg;
    assign m_victim_mip   = victim_mip_reg;

endmodule

[rtl/core/vt_lru_page_cache.sv]
// Top level of the virtual-texture page cache: controller, datapath and checks.
//
// Usage: each request on the s_ channel names a page (x, y, mip) and an
// operation (touch or request). Exactly one result per request comes out on
// the m_ channel: hit flag, whether a slot was assigned and which one, and
// the evicted page if a least recent entry was replaced.
// Resident pages number 0 to MAX_SLOTS. An accepted request is scanned in
// one pass over the tag and recency memories, one entry per cycle, plus
// the registered memory read, then the decide step, which waits for a free
// output register and registers the result. After the result, a recency
// rewrite pass runs before the next request is taken; a touch miss or a
// request hit skips it. Requests are handled one at a time, and each
// memory has a single read port.
// Reset (aresetn low, synchronous) empties the cache and sets slots per
// side to 8; no clearing pass is needed. cfg_wr_en writes slots_per_side
// at once, and should only be used while the cache is idle.
// A stalled receiver holds the result in the output register; the next
// request is still accepted and scanned, and waits only to deliver.
module vt_lru_page_cache #(
    parameter int MAX_SLOTS  = vtlru_pkg::MAX_SLOTS_DEF,
    parameter int COORD_BITS = vtlru_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [vtlru_pkg::SIDE_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [COORD_BITS-1:0]         s_page_x,
    input  logic [COORD_BITS-1:0]         s_page_y,
    input  logic [vtlru_pkg::MIP_W-1:0]   s_page_mip,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_was_resident,
    output logic                          m_loaded,
    output logic [vtlru_pkg::SLOT_W-1:0]  m_slot_col,
    output logic [vtlru_pkg::SLOT_W-1:0]  m_slot_row,
    output logic                          m_evicted,
    output logic [COORD_BITS-1:0]         m_victim_x,
    output logic [COORD_BITS-1:0]         m_victim_y,
    output logic [vtlru_pkg::MIP_W-1:0]   m_victim_mip
);

    vtlru_pkg::cmd_t    cmd;
    vtlru_pkg::status_t status;

    vtlru_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    vtlru_dp #(
        .MAX_SLOTS  (MAX_SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_operation    (s_operation),
        .s_page_x       (s_page_x),
        .s_page_y       (s_page_y),
        .s_page_mip     (s_page_mip),
        .cmd            (cmd),
        .status         (status),
        .m_was_resident (m_was_resident),
        .m_loaded       (m_loaded),
        .m_slot_col     (m_slot_col),
        .m_slot_row     (m_slot_row),
        .m_evicted      (m_evicted),
        .m_victim_x     (m_victim_x),
        .m_victim_y     (m_victim_y),
        .m_victim_mip   (m_victim_mip)
    );

    // a request is never taken while another is in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted twice in a row");

    // a new result only appears from the decide step
    a_valid_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.decide))
        else $error("result valid without a decide step");

    // a hit never loads a slot
    a_hit_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_loaded && m_was_resident))
        else $error("hit reported together with a load");

    // an eviction always comes with a load
    a_evict_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_evicted) |-> m_loaded)
        else $error("eviction without a load");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the LRU page cache: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;

    localparam int COORD_W       = vtlru_pkg::COORD_BITS_DEF;
    localparam int CACHE_DEPTH   = vtlru_pkg::MAX_SLOTS_DEF;
    localparam int SETTLE_CYCLES = 2 * CACHE_DEPTH + 12;
    localparam int DRAIN_CYCLES  = 2 * CACHE_DEPTH + 30;
    localparam int HOLD_CYCLES   = 500;
    localparam int STALL_LIMIT   = 4000;
    localparam int POOL_MAX      = 96;
    localparam int PHASES        = 13;

    localparam logic [vtlru_pkg::SIDE_W-1:0] PHASE_SIDE [PHASES] = '{
        4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd8, 4'd15, 4'd2, 4'd1, 4'd0, 4'd9, 4'd12, 4'd3
    };
    localparam int PHASE_ITEMS [PHASES] = '{
        70, 80, 90, 100, 200, 100, 100, 100, 100, 80, 100, 100, 80
    };

    typedef struct packed {
        logic [COORD_W-1:0]          x;
        logic [COORD_W-1:0]          y;
        logic [vtlru_pkg::MIP_W-1:0] mip;
    } page_t;

    typedef struct packed {
        logic                         was_resident;
        logic                         loaded;
        logic [vtlru_pkg::SLOT_W-1:0] slot_col;
        logic [vtlru_pkg::SLOT_W-1:0] slot_row;
        logic                         evicted;
        logic [COORD_W-1:0]           victim_x;
        logic [COORD_W-1:0]           victim_y;
        logic [vtlru_pkg::MIP_W-1:0]  victim_mip;
    } lookup_t;

    typedef enum logic [1:0] {ROW_SIDE, ROW_PAGE, ROW_FIXED} row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic [vtlru_pkg::SIDE_W-1:0] side;
        logic                         op;
        page_t                        page;
        lookup_t                      want;
    } script_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [vtlru_pkg::SIDE_W-1:0]  cfg_wr_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_operation = vtlru_pkg::OP_TOUCH;
    logic [COORD_W-1:0]            s_page_x = '0;
    logic [COORD_W-1:0]            s_page_y = '0;
    logic [vtlru_pkg::MIP_W-1:0]   s_page_mip = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_was_resident;
    logic                          m_loaded;
    logic [vtlru_pkg::SLOT_W-1:0]  m_slot_col;
    logic [vtlru_pkg::SLOT_W-1:0]  m_slot_row;
    logic                          m_evicted;
    logic [COORD_W-1:0]            m_victim_x;
    logic [COORD_W-1:0]            m_victim_y;
    logic [vtlru_pkg::MIP_W-1:0]   m_victim_mip;

    // shadow copy of the cache contents
    logic [19:0]                   cache_tag  [CACHE_DEPTH];
    int unsigned                   cache_rank [CACHE_DEPTH];
    int unsigned                   cache_count;
    logic [vtlru_pkg::SIDE_W-1:0]  cache_side;

    lookup_t              predicted_lookups [$];
    int unsigned          feed_idle_pct  = 0;
    int unsigned          drain_idle_pct = 0;
    int unsigned          hold_ticket = 0;
    int unsigned          hold_served = 0;
    int unsigned          hold_left   = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          mismatches = 0;
    int unsigned          requests_sent = 0;
    int unsigned          sides_written = 0;
    int unsigned          seen_hits = 0;
    int unsigned          seen_loads = 0;
    int unsigned          seen_evictions = 0;

    vt_lru_page_cache DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_page_x       (s_page_x),
        .s_page_y       (s_page_y),
        .s_page_mip     (s_page_mip),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_was_resident (m_was_resident),
        .m_loaded       (m_loaded),
        .m_slot_col     (m_slot_col),
        .m_slot_row     (m_slot_row),
        .m_evicted      (m_evicted),
        .m_victim_x     (m_victim_x),
        .m_victim_y     (m_victim_y),
        .m_victim_mip   (m_victim_mip)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned effective_side();
        int unsigned n;
        n = cache_side;
        if (n == 0) n = 1;
        if (n > vtlru_pkg::SIDE_MAX) n = vtlru_pkg::SIDE_MAX;
        return n;
    endfunction

    // Age every entry more recent than limit, then make who the most recent.
    function automatic void age_ranks(input int unsigned who, input int unsigned limit);
        for (int unsigned i = 0; i < cache_count; i++) begin
            if (i != who && cache_rank[i] < limit) cache_rank[i] = cache_rank[i] + 1;
        end
        cache_rank[who] = 0;
    endfunction

    function automatic lookup_t predict_lookup(input logic op, input page_t pg);
        lookup_t     r;
        logic [19:0] key;
        int unsigned n, cap, k, oldest, hit;
        bit          found;
        r = '0;
        key = {pg.mip, pg.y, pg.x};
        n = effective_side();
        cap = n * n;
        if (cap > CACHE_DEPTH) cap = CACHE_DEPTH;
        found = 0;
        hit = 0;
        for (int unsigned i = 0; i < cache_count; i++) begin
            if (!found && cache_tag[i] == key) begin
                found = 1;
                hit = i;
            end
        end
        if (found) begin
            r.was_resident = 1'b1;
            if (op == vtlru_pkg::OP_TOUCH) age_ranks(hit, cache_rank[hit]);
            return r;
        end
        if (op == vtlru_pkg::OP_TOUCH) return r;
        if (cache_count >= cap) begin
            // last entry holding the highest rank loses its slot
            oldest = 0;
            k = 0;
            for (int unsigned i = 0; i < cache_count; i++) begin
                if (cache_rank[i] >= oldest) begin
                    oldest = cache_rank[i];
                    k = i;
                end
            end
            r.evicted = 1'b1;
            {r.victim_mip, r.victim_y, r.victim_x} = cache_tag[k];
            cache_tag[k] = key;
            age_ranks(k, oldest);
        end else begin
            k = cache_count;
            cache_tag[k] = key;
            cache_count = cache_count + 1;
            age_ranks(k, 32'hFFFF);
        end
        r.loaded = 1'b1;
        r.slot_col = vtlru_pkg::SLOT_W'(k % n);
        r.slot_row = vtlru_pkg::SLOT_W'(k / n);
        return r;
    endfunction

    function automatic page_t random_page();
        page_t pg;
        pg.x = ($urandom_range(0, 7) == 0) ? {COORD_W{1'($urandom_range(0, 1))}}
                                           : COORD_W'($urandom_range(0, 255));
        pg.y = ($urandom_range(0, 7) == 0) ? {COORD_W{1'($urandom_range(0, 1))}}
                                           : COORD_W'($urandom_range(0, 255));
        // mostly legal mip levels, some out of range
        pg.mip = ($urandom_range(0, 4) == 0) ? vtlru_pkg::MIP_W'($urandom_range(9, 15))
                                             : vtlru_pkg::MIP_W'($urandom_range(0, 8));
        return pg;
    endfunction

    function automatic script_row_t side_row(input logic [vtlru_pkg::SIDE_W-1:0] v);
        script_row_t r;
        r = '0;
        r.kind = ROW_SIDE;
        r.side = v;
        return r;
    endfunction

    function automatic script_row_t page_row(input logic op, input int unsigned x,
                                             input int unsigned y, input int unsigned mip);
        script_row_t r;
        r = '0;
        r.kind = ROW_PAGE;
        r.op = op;
        r.page = '{x: COORD_W'(x), y: COORD_W'(y), mip: vtlru_pkg::MIP_W'(mip)};
        return r;
    endfunction

    function automatic script_row_t fixed_row(input logic op, input int unsigned x,
                                              input int unsigned y, input int unsigned mip,
                                              input logic was, input logic ld,
                                              input int unsigned col, input int unsigned row);
        script_row_t r;
        r = page_row(op, x, y, mip);
        r.kind = ROW_FIXED;
        r.want.was_resident = was;
        r.want.loaded = ld;
        r.want.slot_col = vtlru_pkg::SLOT_W'(col);
        r.want.slot_row = vtlru_pkg::SLOT_W'(row);
        return r;
    endfunction

    // Offer one request, hold it until taken, then queue its expected result.
    task automatic present_page(input logic op, input page_t pg, input logic fixed,
                                input lookup_t fixed_want);
        lookup_t     predicted;
        int unsigned gap;
        s_valid <= 1'b1;
        s_operation <= op;
        s_page_x <= pg.x;
        s_page_y <= pg.y;
        s_page_mip <= pg.mip;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_lookup(op, pg);
        predicted_lookups = {predicted_lookups, (fixed ? fixed_want : predicted)};
        requests_sent++;
        gap = 0;
        while ($urandom_range(0, 99) < feed_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Write slots_per_side only once the cache has gone quiet.
    task automatic write_side(input logic [vtlru_pkg::SIDE_W-1:0] v);
        s_valid <= 1'b0;
        while (predicted_lookups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cache_side = v;
        sides_written++;
    endtask

    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] got, inout bit bad);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
            bad = 1;
        end
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= drain_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_result
        lookup_t want, got;
        bit      bad;
        if (aresetn && m_valid && m_ready) begin
            got = {m_was_resident, m_loaded, m_slot_col, m_slot_row, m_evicted,
                   m_victim_x, m_victim_y, m_victim_mip};
            if (predicted_lookups.size() == 0) begin
                $display("%0t ns: expected no result, actual %h", $time, got);
                mismatches++;
            end else begin
                want = predicted_lookups.pop_front();
                bad = 0;
                compare_field("was_resident", 8'(want.was_resident), 8'(got.was_resident), bad);
                compare_field("loaded", 8'(want.loaded), 8'(got.loaded), bad);
                compare_field("slot_col", 8'(want.slot_col), 8'(got.slot_col), bad);
                compare_field("slot_row", 8'(want.slot_row), 8'(got.slot_row), bad);
                compare_field("evicted", 8'(want.evicted), 8'(got.evicted), bad);
                compare_field("victim_x", want.victim_x, got.victim_x, bad);
                compare_field("victim_y", want.victim_y, got.victim_y, bad);
                compare_field("victim_mip", 8'(want.victim_mip), 8'(got.victim_mip), bad);
                if (bad) mismatches++;
            end
            if (got.was_resident === 1'b1) seen_hits++;
            if (got.loaded === 1'b1) seen_loads++;
            if (got.evicted === 1'b1) seen_evictions++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        script_row_t script [$];
        page_t       page_pool [POOL_MAX];
        page_t       pg;
        int unsigned pool_n, span;
        logic        op;

        // start empty at side 8, fill a few slots, hit and miss both ways
        script = {script, side_row(vtlru_pkg::SIDE_RESET)};
        script = {script, fixed_row(vtlru_pkg::OP_TOUCH,     0,   0,  0, 0, 0, 0, 0)};
        script = {script, fixed_row(vtlru_pkg::OP_REQUEST,   0,   0,  0, 0, 1, 0, 0)};
        script = {script, fixed_row(vtlru_pkg::OP_REQUEST,   0,   0,  0, 1, 0, 0, 0)};
        script = {script, fixed_row(vtlru_pkg::OP_TOUCH,     0,   0,  0, 1, 0, 0, 0)};
        script = {script, fixed_row(vtlru_pkg::OP_REQUEST, 255, 255, 15, 0, 1, 1, 0)};
        script = {script, fixed_row(vtlru_pkg::OP_REQUEST, 255,   0,  8, 0, 1, 2, 0)};
        script = {script, fixed_row(vtlru_pkg::OP_REQUEST,   0, 255,  0, 0, 1, 3, 0)};
        script = {script, fixed_row(vtlru_pkg::OP_TOUCH,   170,  85,  9, 0, 0, 0, 0)};
        script = {script, fixed_row(vtlru_pkg::OP_REQUEST, 170,  85,  9, 0, 1, 4, 0)};
        script = {script, fixed_row(vtlru_pkg::OP_REQUEST,  85, 170,  6, 0, 1, 5, 0)};
        script = {script, fixed_row(vtlru_pkg::OP_TOUCH,   255, 255, 15, 1, 0, 0, 0)};
        // shrink capacity below the resident count: every miss evicts
        script = {script, side_row(4'd1)};
        script = {script, page_row(vtlru_pkg::OP_REQUEST,  1,  1,  1)};
        script = {script, page_row(vtlru_pkg::OP_REQUEST,  2,  2,  2)};
        script = {script, page_row(vtlru_pkg::OP_TOUCH,    1,  1,  1)};
        script = {script, page_row(vtlru_pkg::OP_REQUEST, 255, 255, 15)};
        script = {script, side_row(4'd0)};
        script = {script, page_row(vtlru_pkg::OP_REQUEST,  3,  3,  3)};
        script = {script, page_row(vtlru_pkg::OP_REQUEST,  0,  0,  0)};
        // oversize side acts as 8: loads resume at the next free entry
        script = {script, side_row(4'd15)};
        script = {script, fixed_row(vtlru_pkg::OP_REQUEST, 7, 7, 7, 0, 1, 6, 0)};
        script = {script, fixed_row(vtlru_pkg::OP_REQUEST, 8, 8, 8, 0, 1, 7, 0)};
        script = {script, fixed_row(vtlru_pkg::OP_REQUEST, 9, 9, 9, 0, 1, 0, 1)};
        script = {script, side_row(4'd3)};
        script = {script, page_row(vtlru_pkg::OP_REQUEST, 10, 10, 10)};
        script = {script, page_row(vtlru_pkg::OP_TOUCH,    9,  9,  9)};

        cache_side = vtlru_pkg::SIDE_RESET;
        cache_count = 0;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            cache_tag[i] = '0;
            cache_rank[i] = 0;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        feed_idle_pct = 36;
        drain_idle_pct = 79;
        foreach (script[i]) begin
            if (script[i].kind == ROW_SIDE) begin
                write_side(script[i].side);
            end else begin
                present_page(script[i].op, script[i].page, script[i].kind == ROW_FIXED,
                             script[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_side(PHASE_SIDE[p]);
            if (p < 5) begin
                feed_idle_pct = 36;
                drain_idle_pct = 79;
            end else if (p < 9) begin
                feed_idle_pct = 79;
                drain_idle_pct = 36;
            end else begin
                feed_idle_pct = 0;
                drain_idle_pct = 0;
            end
            // stall the result side long enough to back up the input
            if (p == 6 || p == 10) hold_ticket++;
            span = effective_side() * effective_side();
            if (cache_count > span) span = cache_count;
            pool_n = span * 3 / 2 + 4;
            if (pool_n > POOL_MAX) pool_n = POOL_MAX;
            for (int i = 0; i < pool_n; i++) page_pool[i] = random_page();
            for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
                pg = ($urandom_range(0, 99) < 85) ? page_pool[$urandom_range(0, pool_n - 1)]
                                                  : random_page();
                op = ($urandom_range(0, 99) < 55) ? vtlru_pkg::OP_REQUEST
                                                  : vtlru_pkg::OP_TOUCH;
                present_page(op, pg, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (predicted_lookups.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d page lookups across %0d slot-side writes, including sides 0, 1, 8, 15.",
                 requests_sent, sides_written);
        $display("Results seen: %0d resident hits, %0d loads, %0d evictions.",
                 seen_hits, seen_loads, seen_evictions);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
